// ----- rtl/mrrp_pkg.sv -----
package mrrp_pkg;

  localparam int unsigned MaxFrameBytesDefault = 253;

  // Function codes of the read requests
  localparam logic [7:0] FN_READ_COILS    = 8'd1;
  localparam logic [7:0] FN_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FN_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FN_READ_INPUT    = 8'd4;
  localparam logic [7:0] EXC_FLAG         = 8'h80;

  // Configuration register indexes
  localparam logic CFG_REQ_FUNCTION = 1'b0;
  localparam logic CFG_REQ_QUANTITY = 1'b1;

  localparam logic [7:0]  REQ_FUNCTION_RST = FN_READ_HOLDING;
  localparam logic [10:0] REQ_QUANTITY_RST = 11'd1;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_LEN   = 3'd2,
    ST_QTY   = 3'd3,
    ST_EXC   = 3'd4,
    ST_BADFN = 3'd5
  } status_t;

  // Work left over from one accepted byte: value results, then maybe a status
  typedef struct packed {
    logic [3:0]  vals;     // value results still to emit (0..8)
    logic [10:0] base;     // index of the first value
    logic [15:0] data;     // register word, or coil byte in the low half
    logic        is_bits;
    logic        stat;     // a status result follows the values
    status_t     status;
    logic [7:0]  exc;
  } job_t;

endpackage

// ----- rtl/mrrp_parse.sv -----
module mrrp_parse #(
  parameter int unsigned MAX_FRAME_BYTES = mrrp_pkg::MaxFrameBytesDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       req_function,
  input  logic [10:0]      req_quantity,
  input  logic [7:0]       rx_byte,
  input  logic             end_of_frame,
  input  logic             accept,
  output mrrp_pkg::job_t   job
);
  import mrrp_pkg::*;

  localparam logic [8:0] MaxPos = 9'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    FK_NONE  = 2'd0,
    FK_REGS  = 2'd1,
    FK_BITS  = 2'd2,
    FK_OTHER = 2'd3
  } frame_kind_t;

  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  reply_function, reply_function_next;
  logic [7:0]  declared_count, declared_count_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [10:0] values_emitted, values_emitted_next;
  frame_kind_t frame_kind, frame_kind_next;

  logic        decode_en;
  logic [10:0] room;
  logic [3:0]  nvals;
  logic [8:0]  len_sum;
  logic [11:0] bytes_for_bits;
  status_t     status;

  always_comb begin
    byte_position_next  = (byte_position != 8'hFF) ? byte_position + 8'd1 : byte_position;
    reply_function_next = reply_function;
    frame_kind_next     = frame_kind;
    declared_count_next = declared_count;
    high_byte_hold_next = high_byte_hold;

    if (byte_position == 8'd0) begin
      reply_function_next = rx_byte;
      if (rx_byte == req_function) begin
        case (rx_byte) inside
          FN_READ_HOLDING, FN_READ_INPUT:   frame_kind_next = FK_REGS;
          FN_READ_COILS, FN_READ_DISCRETE:  frame_kind_next = FK_BITS;
          default:                          frame_kind_next = FK_NONE;
        endcase
      end else begin
        frame_kind_next = FK_OTHER;
      end
    end
    if (byte_position == 8'd1) begin
      declared_count_next = rx_byte;
    end

    decode_en = (byte_position >= 8'd2) && ({1'b0, byte_position} < MaxPos);
    room      = (values_emitted < req_quantity) ? req_quantity - values_emitted : 11'd0;
    nvals     = 4'd0;
    if (decode_en && frame_kind == FK_REGS) begin
      if (!byte_position[0]) begin
        high_byte_hold_next = rx_byte;
      end else if (room != 11'd0) begin
        nvals = 4'd1;
      end
    end else if (decode_en && frame_kind == FK_BITS) begin
      nvals = (room >= 11'd8) ? 4'd8 : room[3:0];
    end
    values_emitted_next = values_emitted + {7'd0, nvals};

    // Frame checks on the state as it stands after this byte
    len_sum        = {1'b0, declared_count_next} + 9'd2;
    bytes_for_bits = ({1'b0, req_quantity} + 12'd7) >> 3;
    if (byte_position_next < 8'd2) begin
      status = ST_SHORT;
    end else if (frame_kind_next == FK_OTHER) begin
      status = (reply_function_next == (req_function | EXC_FLAG)) ? ST_EXC : ST_BADFN;
    end else if ({1'b0, byte_position_next} > MaxPos ||
                 len_sum != {1'b0, byte_position_next}) begin
      status = ST_LEN;
    end else if (frame_kind_next == FK_REGS &&
                 {4'd0, declared_count_next} != {req_quantity, 1'b0}) begin
      status = ST_QTY;
    end else if (frame_kind_next == FK_BITS &&
                 {4'd0, declared_count_next} != bytes_for_bits) begin
      status = ST_QTY;
    end else begin
      status = ST_OK;
    end

    job.vals    = nvals;
    job.base    = values_emitted;
    job.is_bits = (frame_kind == FK_BITS);
    job.data    = (frame_kind == FK_BITS) ? {8'd0, rx_byte} : {high_byte_hold, rx_byte};
    job.stat    = end_of_frame;
    job.status  = status;
    job.exc     = (status == ST_EXC) ? declared_count_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_frame)) begin
      byte_position  <= 8'd0;
      reply_function <= 8'd0;
      declared_count <= 8'd0;
      high_byte_hold <= 8'd0;
      values_emitted <= 11'd0;
      frame_kind     <= FK_NONE;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      reply_function <= reply_function_next;
      declared_count <= declared_count_next;
      high_byte_hold <= high_byte_hold_next;
      values_emitted <= values_emitted_next;
      frame_kind     <= frame_kind_next;
    end
  end

endmodule

// ----- rtl/mrrp_emit.sv -----
module mrrp_emit (
  input  logic           clk,
  input  logic           rst,
  input  mrrp_pkg::job_t job,
  input  logic           byte_valid,
  output logic           byte_stall,
  output logic           accept,
  output logic           result_valid,
  input  logic           result_stall,
  output logic           kind,
  output logic [15:0]    value,
  output logic [10:0]    value_index,
  output logic [2:0]     status,
  output logic [7:0]     exc_code,
  output logic           last
);
  import mrrp_pkg::*;

  job_t       job_q;
  logic [2:0] job_sub;
  logic       job_busy;
  logic       job_last;
  logic       move;
  logic [7:0] bit_byte;

  assign job_busy   = (job_q.vals != 4'd0) || job_q.stat;
  assign job_last   = (job_q.vals == 4'd1 && !job_q.stat) ||
                      (job_q.vals == 4'd0 && job_q.stat);
  assign move       = job_busy && (!result_valid || !result_stall);
  assign byte_stall = job_busy && !(move && job_last);
  assign accept     = byte_valid && !byte_stall;
  assign bit_byte   = job_q.data[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      job_q.vals   <= 4'd0;
      job_q.stat   <= 1'b0;
      job_sub      <= 3'd0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        job_q   <= job;
        job_sub <= 3'd0;
      end else if (move) begin
        // advance through the values, then drop the status
        if (job_q.vals != 4'd0) begin
          job_q.vals <= job_q.vals - 4'd1;
          job_sub    <= job_sub + 3'd1;
        end else begin
          job_q.stat <= 1'b0;
        end
      end

      if (move) begin
        result_valid <= 1'b1;
        if (job_q.vals != 4'd0) begin
          kind        <= 1'b0;
          value       <= job_q.is_bits ? {15'd0, bit_byte[job_sub]} : job_q.data;
          value_index <= job_q.base + {8'd0, job_sub};
          status      <= ST_OK;
          exc_code    <= 8'd0;
          last        <= 1'b0;
        end else begin
          kind        <= 1'b1;
          value       <= 16'd0;
          value_index <= 11'd0;
          status      <= job_q.status;
          exc_code    <= job_q.exc;
          last        <= 1'b1;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_vals_range: assert property (@(posedge clk) disable iff (rst)
    job_q.vals <= 4'd8)
    else $error("job holds more than eight values");

  a_value_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !kind |-> !last && status == ST_OK && exc_code == 8'd0)
    else $error("value item carries status fields");

  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind |-> last && value == 16'd0 && value_index == 11'd0)
    else $error("status item carries value fields");

  a_sub_advance: assert property (@(posedge clk) disable iff (rst)
    move && !accept && job_q.vals != 4'd0 |=> job_sub == $past(job_sub) + 3'd1)
    else $error("bit offset did not advance");

endmodule

// ----- rtl/modbus_read_response_parser.sv -----
// Modbus read-response parser. Takes the response PDU one byte per item,
// function code first, with end_of_frame on the last byte, and emits one value
// item per register word (codes 3 and 4) or per coil/discrete bit (codes 1 and
// 2, LSB first, stopping at req_quantity), then one status item with last set
// when the frame ends. Values leave before the frame is checked. Each byte is
// decoded in the cycle it is accepted into a work register, and a single
// output register drains that work at one item per cycle while result_stall
// is low. byte_stall holds off the next byte until the work drains, the next
// byte going in as the last item leaves, so a byte causing no item or one is
// followed by the next byte in the next cycle unless the output stalls. A coil
// byte causes up to eight value items, plus the status item if it ends the
// frame. Configuration writes are always ready and take effect on the next
// byte; the request function and quantity reset to 3 and 1.
module modbus_read_response_parser #(
  parameter int unsigned MAX_FRAME_BYTES = mrrp_pkg::MaxFrameBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_frame,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [15:0] value,
  output logic [10:0] value_index,
  output logic [2:0]  status,
  output logic [7:0]  exc_code,
  output logic        last
);
  import mrrp_pkg::*;

  logic [7:0]  req_function;
  logic [10:0] req_quantity;
  logic        accept;
  job_t        job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_function <= REQ_FUNCTION_RST;
      req_quantity <= REQ_QUANTITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REQ_FUNCTION: req_function <= cfg_data[7:0];
        CFG_REQ_QUANTITY: req_quantity <= cfg_data;
        default: ;
      endcase
    end
  end

  mrrp_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .req_function (req_function),
    .req_quantity (req_quantity),
    .rx_byte      (rx_byte),
    .end_of_frame (end_of_frame),
    .accept       (accept),
    .job          (job)
  );

  mrrp_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .accept       (accept),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .value        (value),
    .value_index  (value_index),
    .status       (status),
    .exc_code     (exc_code),
    .last         (last)
  );

endmodule

// ----- sim/tb_modbus_read_response_parser.sv -----
`timescale 1ns / 100ps

module tb_modbus_read_response_parser;
  import mrrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES = 160;
  localparam int SETTLE_CYCLES = 12;

  typedef enum logic [1:0] {
    FRM_UNKNOWN,
    FRM_REGS,
    FRM_BITS,
    FRM_FOREIGN
  } frame_kind_t;

  typedef struct {
    logic        kind;
    logic [15:0] value;
    logic [10:0] value_index;
    status_t     status;
    logic [7:0]  exc_code;
    logic        last;
  } parse_result_t;

  // Tracks the parser state byte by byte and holds the items it must emit
  class frame_scoreboard;
    logic [7:0]    req_fn;
    logic [10:0]   req_qty;
    logic [7:0]    pos;
    logic [7:0]    reply_fn;
    logic [7:0]    decl_count;
    logic [7:0]    hi_byte;
    logic [10:0]   emitted;
    frame_kind_t   fk;
    parse_result_t pending[$];
    int            failures;
    int            values_checked;
    int            frames_checked;

    function new();
      req_fn = REQ_FUNCTION_RST;
      req_qty = REQ_QUANTITY_RST;
      failures = 0;
      values_checked = 0;
      frames_checked = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = '0;
      reply_fn = '0;
      decl_count = '0;
      hi_byte = '0;
      emitted = '0;
      fk = FRM_UNKNOWN;
    endfunction

    function void write_reg(logic idx, logic [10:0] data);
      if (idx == CFG_REQ_FUNCTION) begin
        req_fn = data[7:0];
      end else begin
        req_qty = data;
      end
    endfunction

    function status_t close_status();
      int unsigned qty;
      qty = req_qty;
      if (pos < 2) return ST_SHORT;
      if (fk == FRM_FOREIGN) return (reply_fn == (req_fn | EXC_FLAG)) ? ST_EXC : ST_BADFN;
      if (pos > MaxFrameBytesDefault || int'(decl_count) + 2 != int'(pos)) return ST_LEN;
      if (fk == FRM_REGS && int'(decl_count) != 2 * qty) return ST_QTY;
      if (fk == FRM_BITS && int'(decl_count) != (qty + 7) / 8) return ST_QTY;
      return ST_OK;
    endfunction

    function void push_value(logic [15:0] v);
      pending.push_back('{1'b0, v, emitted, ST_OK, 8'h00, 1'b0});
      emitted++;
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      logic [7:0] k;
      status_t    st;
      if (pos == 0) begin
        reply_fn = b;
        if (b != req_fn) begin
          fk = FRM_FOREIGN;
        end else if (b == FN_READ_HOLDING || b == FN_READ_INPUT) begin
          fk = FRM_REGS;
        end else if (b == FN_READ_COILS || b == FN_READ_DISCRETE) begin
          fk = FRM_BITS;
        end else begin
          fk = FRM_UNKNOWN;
        end
      end else if (pos == 1) begin
        decl_count = b;
      end else if (pos < MaxFrameBytesDefault) begin
        k = pos - 8'd2;
        if (fk == FRM_REGS) begin
          // even payload byte is the high half of a register word
          if (!k[0]) begin
            hi_byte = b;
          end else if (emitted < req_qty) begin
            push_value({hi_byte, b});
          end
        end else if (fk == FRM_BITS) begin
          for (int i = 0; i < 8; i++) begin
            if (emitted < req_qty) push_value({15'd0, b[i]});
          end
        end
      end
      if (pos != 8'd255) pos++;
      if (eof) begin
        st = close_status();
        pending.push_back('{1'b1, 16'h0000, 11'd0, st,
                           (st == ST_EXC) ? decl_count : 8'h00, 1'b1});
        clear_frame();
      end
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (pending.size() == 0) begin
        $error("result with no item expected: kind %0d value 0x%0h status %0d",
               got.kind, got.value, got.status);
        failures++;
        return;
      end
      want = pending.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("value", want.value, got.value);
      compare_field("value_index", want.value_index, got.value_index);
      compare_field("status", want.status, got.status);
      compare_field("exc_code", want.exc_code, got.exc_code);
      compare_field("last", want.last, got.last);
      if (want.kind) frames_checked++;
      else values_checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [10:0] cfg_data;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  rx_byte;
  logic        end_of_frame;
  logic        result_valid;
  logic        result_stall;
  logic        kind;
  logic [15:0] value;
  logic [10:0] value_index;
  logic [2:0]  status;
  logic [7:0]  exc_code;
  logic        last;

  frame_scoreboard sb = new();
  logic [7:0]      frame_bytes[$];
  int              bytes_sent = 0;
  int              settings_used = 0;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  bit              no_idle = 0;

  modbus_read_response_parser dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .rx_byte      (rx_byte),
    .end_of_frame (end_of_frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .value        (value),
    .value_index  (value_index),
    .status       (status),
    .exc_code     (exc_code),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result('{kind, value, value_index, status_t'(status), exc_code, last});
      stall_left = draw_gap();
      result_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      result_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx_byte <= b;
    end_of_frame <= eof;
    do @(posedge clk); while (byte_stall);
    sb.note_byte(b, eof);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  // Drain every pending item, then let a header byte still in flight settle
  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_request(input logic [7:0] fn, input logic [10:0] qty);
    logic        idx[2];
    logic [10:0] data[2];
    idx[0] = CFG_REQ_FUNCTION;
    data[0] = {3'd0, fn};
    idx[1] = CFG_REQ_QUANTITY;
    data[1] = qty;
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= data[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], data[i]);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random_frame();
    int shape;
    int count;
    shape = $urandom_range(0, 99);
    frame_bytes.delete();
    if (shape < 60) begin
      // well-formed echo, usually with the byte count that the request implies
      if (sb.req_fn == FN_READ_HOLDING || sb.req_fn == FN_READ_INPUT) begin
        count = 2 * int'(sb.req_qty);
      end else if (sb.req_fn == FN_READ_COILS || sb.req_fn == FN_READ_DISCRETE) begin
        count = (int'(sb.req_qty) + 7) / 8;
      end else begin
        count = $urandom_range(0, 8);
      end
      if (count > 40 || $urandom_range(0, 4) == 0) count = $urandom_range(0, 16);
      frame_bytes.push_back(sb.req_fn);
      frame_bytes.push_back(8'(count));
      repeat (count) frame_bytes.push_back(8'($urandom));
    end else if (shape < 70) begin
      frame_bytes.push_back(sb.req_fn);
      frame_bytes.push_back(8'($urandom_range(0, 16)));
      repeat ($urandom_range(0, 18)) frame_bytes.push_back(8'($urandom));
    end else if (shape < 80) begin
      frame_bytes.push_back(sb.req_fn | EXC_FLAG);
      frame_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 3) == 0) frame_bytes.push_back(8'($urandom));
    end else if (shape < 88) begin
      repeat ($urandom_range(2, 8)) frame_bytes.push_back(8'($urandom));
    end else if (shape < 94) begin
      frame_bytes.push_back($urandom_range(0, 1) ? sb.req_fn : 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
    end
    send_frame();
  endtask

  initial begin
    int random_start;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_REQ_FUNCTION;
    cfg_data <= '0;
    byte_valid <= 1'b0;
    rx_byte <= '0;
    end_of_frame <= 1'b0;
    result_stall <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register reply under the reset request, then short, exception, foreign
    frame_bytes = '{8'h03, 8'h02, 8'h12, 8'h34};
    send_frame();
    frame_bytes = '{8'h03};
    send_frame();
    frame_bytes = '{8'h83, 8'h02};
    send_frame();
    frame_bytes = '{8'h05, 8'h00};
    send_frame();
    wait_idle();
    program_request(FN_READ_COILS, 11'd10);
    frame_bytes = '{8'h01, 8'h02, 8'hA5, 8'hFF};
    send_frame();
    wait_idle();
    // echoed code outside the read set: only the length check applies
    program_request(8'h00, 11'd0);
    frame_bytes = '{8'h00, 8'h00};
    send_frame();
    frame_bytes = '{8'h80, 8'h7F};
    send_frame();
    wait_idle();
    program_request(8'hFF, 11'd2000);
    frame_bytes = '{8'hFF, 8'h01, 8'h00};
    send_frame();
    wait_idle();
    // payload past the byte count, stops at quantity, odd trailing byte
    program_request(FN_READ_INPUT, 11'd2);
    frame_bytes = '{8'h04, 8'h02, 8'h00, 8'h01, 8'hFF, 8'hFE, 8'h77};
    send_frame();
    wait_idle();
    // frame kind holds from the first byte when the request changes mid-frame
    program_request(FN_READ_HOLDING, 11'd2);
    send_byte(8'h03, 1'b0);
    wait_idle();
    program_request(FN_READ_COILS, 11'd2);
    send_byte(8'h04, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b1);
    send_byte(8'h83, 1'b0);
    wait_idle();
    program_request(FN_READ_HOLDING, 11'd2);
    send_byte(8'h01, 1'b1);
    wait_idle();

    // overlong coil frame saturates the length counter
    no_idle = 1;
    program_request(FN_READ_COILS, 11'd2000);
    frame_bytes = '{8'h01, 8'd250};
    repeat (254) frame_bytes.push_back(8'($urandom));
    send_frame();
    wait_idle();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0);
      program_request(($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 4)) : 8'($urandom),
                      ($urandom_range(0, 19) == 0) ? 11'($urandom_range(0, 2000))
                                                   : 11'($urandom_range(0, 24)));
      repeat ($urandom_range(2, 5)) send_random_frame();
    end

    byte_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes under %0d request settings, stalls on both sides.",
             bytes_sent, settings_used);
    $display("Checked %0d decoded values and %0d frame status items, %0d mismatches.",
             sb.values_checked, sb.frames_checked, sb.failures);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
